// ===== sv/tsmm_pkg.sv =====
// Shared types, constants and helpers of the traffic signal module mill.
package tsmm_pkg;

   localparam int PHASE_W         = 16;
   localparam int MODULE_W        = 3;
   localparam int MODULE_SLOTS    = 6;
   localparam int NUM_PHASES_DEF  = 16;
   localparam int MAX_MODULES_DEF = 6;
   localparam int CSR_ADDR_W      = 5;
   localparam int CSR_DATA_W      = 32;

   localparam logic [MODULE_W-1:0] MODULE_COUNT_RST = 3'd4;
   localparam logic [MODULE_W-1:0] PARK_MODULE_RST  = 3'd0;

   typedef enum logic [2:0] {
      REG_MODULE_COUNT   = 3'd0,
      REG_PARK_MODULE    = 3'd1,
      REG_MODULE0_PHASES = 3'd2,
      REG_MODULE1_PHASES = 3'd3,
      REG_MODULE2_PHASES = 3'd4,
      REG_MODULE3_PHASES = 3'd5,
      REG_MODULE4_PHASES = 3'd6,
      REG_MODULE5_PHASES = 3'd7
   } tsmm_reg_type;

   typedef logic [PHASE_W-1:0] tsmm_mask_type;

   typedef struct packed {
      logic [MODULE_W-1:0]                  module_count;
      logic [MODULE_W-1:0]                  park_module;
      logic [MODULE_SLOTS-1:0][PHASE_W-1:0] module_phases;
   } tsmm_cfg_type;

   typedef struct packed {
      logic [MODULE_W-1:0] active_index;
      tsmm_mask_type       primary_bits;
      tsmm_mask_type       realised_bits;
      tsmm_mask_type       skipped_bits;
   } tsmm_state_type;

   typedef struct packed {
      logic [MODULE_W-1:0] active_module;
      logic                module_start;
      logic                all_realised;
      tsmm_mask_type       primary_flags;
      tsmm_mask_type       realised_flags;
      tsmm_mask_type       skipped_flags;
   } tsmm_result_type;

   // Bits of phases that exist; phases at or above the phase count are masked off.
   function automatic tsmm_mask_type phase_mask(input int num_phases);
      tsmm_mask_type m;
      for (int i = 0; i < PHASE_W; i++) begin
         m[i] = (i < num_phases);
      end
      return m;
   endfunction

endpackage

// ===== sv/tsmm_req_if.sv =====
// Input channel: one beat carries the request, not-red and green masks of a tick.
interface tsmm_req_if
   import tsmm_pkg::*;
();
   logic          valid;
   logic          ready;
   tsmm_mask_type request_mask;
   tsmm_mask_type nonred_mask;
   tsmm_mask_type green_mask;

   modport source (output valid, output request_mask, output nonred_mask,
                   output green_mask, input ready);
   modport sink   (input valid, input request_mask, input nonred_mask,
                   input green_mask, output ready);
endinterface

// ===== sv/tsmm_rsp_if.sv =====
// Result channel: one beat carries the mill position and flags after a tick.
interface tsmm_rsp_if
   import tsmm_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [MODULE_W-1:0] active_module;
   logic                module_start;
   logic                all_realised;
   tsmm_mask_type       primary_flags;
   tsmm_mask_type       realised_flags;
   tsmm_mask_type       skipped_flags;

   modport source (output valid, output active_module, output module_start,
                   output all_realised, output primary_flags, output realised_flags,
                   output skipped_flags, input ready);
   modport sink   (input valid, input active_module, input module_start,
                   input all_realised, input primary_flags, input realised_flags,
                   input skipped_flags, output ready);
endinterface

// ===== sv/tsmm_csr.sv =====
// Configuration register file behind the APB-style port.
module tsmm_csr
   import tsmm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output tsmm_cfg_type          cfg
);

   logic [MODULE_W-1:0]                  module_count_ff;
   logic [MODULE_W-1:0]                  park_module_ff;
   logic [MODULE_SLOTS-1:0][PHASE_W-1:0] phases_ff;
   logic [MODULE_W-1:0]                  module_count_in;
   logic [MODULE_W-1:0]                  park_module_in;
   logic [MODULE_SLOTS-1:0][PHASE_W-1:0] phases_in;
   tsmm_reg_type                         reg_sel;
   logic                                 wr_en;
   logic [MODULE_W-1:0]                  wr_small;
   tsmm_mask_type                        wr_mask;

   assign csr_pready = 1'b1;
   assign reg_sel    = tsmm_reg_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign wr_small   = csr_pwdata[MODULE_W-1:0];
   assign wr_mask    = csr_pwdata[PHASE_W-1:0];

   always_comb begin
      module_count_in = module_count_ff;
      park_module_in  = park_module_ff;
      phases_in       = phases_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_MODULE_COUNT:   module_count_in = wr_small;
            REG_PARK_MODULE:    park_module_in  = wr_small;
            REG_MODULE0_PHASES: phases_in[0]    = wr_mask;
            REG_MODULE1_PHASES: phases_in[1]    = wr_mask;
            REG_MODULE2_PHASES: phases_in[2]    = wr_mask;
            REG_MODULE3_PHASES: phases_in[3]    = wr_mask;
            REG_MODULE4_PHASES: phases_in[4]    = wr_mask;
            REG_MODULE5_PHASES: phases_in[5]    = wr_mask;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         module_count_ff <= MODULE_COUNT_RST;
         park_module_ff  <= PARK_MODULE_RST;
         phases_ff       <= '0;
      end else begin
         module_count_ff <= module_count_in;
         park_module_ff  <= park_module_in;
         phases_ff       <= phases_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      case (reg_sel)
         REG_MODULE_COUNT:   csr_prdata[MODULE_W-1:0] = module_count_ff;
         REG_PARK_MODULE:    csr_prdata[MODULE_W-1:0] = park_module_ff;
         REG_MODULE0_PHASES: csr_prdata[PHASE_W-1:0]  = phases_ff[0];
         REG_MODULE1_PHASES: csr_prdata[PHASE_W-1:0]  = phases_ff[1];
         REG_MODULE2_PHASES: csr_prdata[PHASE_W-1:0]  = phases_ff[2];
         REG_MODULE3_PHASES: csr_prdata[PHASE_W-1:0]  = phases_ff[3];
         REG_MODULE4_PHASES: csr_prdata[PHASE_W-1:0]  = phases_ff[4];
         REG_MODULE5_PHASES: csr_prdata[PHASE_W-1:0]  = phases_ff[5];
         default:            csr_prdata = '0;
      endcase
   end

   assign cfg.module_count  = module_count_ff;
   assign cfg.park_module   = park_module_ff;
   assign cfg.module_phases = phases_ff;

endmodule

// ===== sv/tsmm_step.sv =====
// Next-state logic of one control tick: flag update of the active module and the move.
module tsmm_step
   import tsmm_pkg::*;
#(
   parameter int NUM_PHASES  = NUM_PHASES_DEF,
   parameter int MAX_MODULES = MAX_MODULES_DEF
) (
   input  tsmm_cfg_type    cfg,
   input  tsmm_state_type  state,
   input  tsmm_mask_type   request_mask,
   input  tsmm_mask_type   nonred_mask,
   input  tsmm_mask_type   green_mask,
   output tsmm_state_type  state_next,
   output tsmm_result_type result
);

   localparam tsmm_mask_type       PhaseMask = phase_mask(NUM_PHASES);
   localparam logic [MODULE_W-1:0] MaxCount  = MODULE_W'(MAX_MODULES);

   tsmm_mask_type       req;
   tsmm_mask_type       nonred;
   tsmm_mask_type       green;
   tsmm_mask_type       mod;
   logic [MODULE_W-1:0] count;
   logic                started;
   tsmm_mask_type       done0;
   tsmm_mask_type       prim1;
   tsmm_mask_type       real1;
   tsmm_mask_type       skip1;
   tsmm_mask_type       done2;
   logic                all_real;
   logic                wait_here;
   logic [MODULE_W-1:0] index_inc;
   logic [MODULE_W-1:0] index_next;
   logic                advance;

   assign req    = request_mask & PhaseMask;
   assign nonred = nonred_mask & PhaseMask;
   assign green  = green_mask & PhaseMask;

   // An index beyond the module slots serves an empty module.
   assign mod = (state.active_index < MODULE_W'(MODULE_SLOTS))
                ? (cfg.module_phases[state.active_index] & PhaseMask) : '0;

   always_comb begin
      count = cfg.module_count;
      if (count == '0) begin
         count = MODULE_W'(1);
      end
      if (count > MaxCount) begin
         count = MaxCount;
      end
   end

   assign started = |(mod & nonred);
   assign done0   = state.realised_bits | state.skipped_bits;
   assign prim1   = state.primary_bits | (mod & req & ~done0);
   assign real1   = state.realised_bits | (mod & green & prim1 & ~done0);
   assign skip1   = started
                    ? (state.skipped_bits | (mod & ~(real1 | state.skipped_bits) & ~req))
                    : state.skipped_bits;
   assign done2    = real1 | skip1;
   assign all_real = ((mod & req & ~done2) == '0);

   assign wait_here = (cfg.park_module < count) &&
                      (state.active_index == cfg.park_module) && (req == '0);
   assign advance   = all_real && !wait_here;
   assign index_inc = state.active_index + MODULE_W'(1);
   assign index_next = (index_inc >= count) ? '0 : index_inc;

   always_comb begin
      state_next.active_index  = advance ? index_next : state.active_index;
      state_next.primary_bits  = all_real ? (prim1 & ~mod) : prim1;
      state_next.realised_bits = all_real ? (real1 & ~mod) : real1;
      state_next.skipped_bits  = all_real ? (skip1 & ~mod) : skip1;
   end

   assign result.active_module  = state_next.active_index;
   assign result.module_start   = advance;
   assign result.all_realised   = all_real;
   assign result.primary_flags  = state_next.primary_bits;
   assign result.realised_flags = state_next.realised_bits;
   assign result.skipped_flags  = state_next.skipped_bits;

endmodule

// ===== sv/traffic_signal_module_mill.sv =====
// Module mill top level: input register, tick logic with flag state, result register.
// An accepted beat waits in the input register and passes into the result register once that is free.
// Throughput: one tick per cycle when results are taken; the input register fills while a result waits.
// Reset (synchronous, active high) empties both registers, clears all flags and
// sets the active module to zero; configuration returns to count four, wait module zero.
module traffic_signal_module_mill
   import tsmm_pkg::*;
#(
   parameter int NUM_PHASES  = NUM_PHASES_DEF,
   parameter int MAX_MODULES = MAX_MODULES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   tsmm_req_if.sink              req_chan,
   tsmm_rsp_if.source            rsp_chan,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   tsmm_cfg_type    cfg;
   logic            in_valid_ff;
   tsmm_mask_type   request_ff;
   tsmm_mask_type   nonred_ff;
   tsmm_mask_type   green_ff;
   logic            out_valid_ff;
   tsmm_result_type result_ff;
   tsmm_state_type  state_ff;
   tsmm_state_type  state_in;
   tsmm_result_type result_in;
   logic            step_go;
   logic            take_in;

   tsmm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   tsmm_step #(
      .NUM_PHASES  (NUM_PHASES),
      .MAX_MODULES (MAX_MODULES)
   ) u_step (
      .cfg          (cfg),
      .state        (state_ff),
      .request_mask (request_ff),
      .nonred_mask  (nonred_ff),
      .green_mask   (green_ff),
      .state_next   (state_in),
      .result       (result_in)
   );

   // The flag state moves only when a held beat passes into the result register.
   assign step_go        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || step_go;
   assign take_in        = req_chan.valid && req_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         if (take_in) begin
            in_valid_ff <= 1'b1;
         end else if (step_go) begin
            in_valid_ff <= 1'b0;
         end
         if (step_go) begin
            out_valid_ff <= 1'b1;
            state_ff     <= state_in;
         end else if (rsp_chan.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take_in) begin
         request_ff <= req_chan.request_mask;
         nonred_ff  <= req_chan.nonred_mask;
         green_ff   <= req_chan.green_mask;
      end
      if (step_go) begin
         result_ff <= result_in;
      end
   end

   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.active_module  = result_ff.active_module;
   assign rsp_chan.module_start   = result_ff.module_start;
   assign rsp_chan.all_realised   = result_ff.all_realised;
   assign rsp_chan.primary_flags  = result_ff.primary_flags;
   assign rsp_chan.realised_flags = result_ff.realised_flags;
   assign rsp_chan.skipped_flags  = result_ff.skipped_flags;

endmodule

// ===== sv/tsmm_checker.sv =====
// Port-level checker of the module mill and its binding to the top level.
module tsmm_checker
   import tsmm_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [MODULE_W-1:0] active_module,
   input logic                module_start,
   input logic                all_realised,
   input tsmm_mask_type       primary_flags,
   input tsmm_mask_type       realised_flags,
   input tsmm_mask_type       skipped_flags
);

   // A stalled result beat keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(active_module) &&
      $stable(primary_flags) && $stable(realised_flags) && $stable(skipped_flags))
      else $error("result beat changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid straight after reset");

   // The mill only moves on once the served module has nothing left undone.
   a_start_needs_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && module_start |-> all_realised)
      else $error("module advanced with requesting phases left");

   a_index_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> active_module < MODULE_W'(MAX_MODULES_DEF))
      else $error("active module beyond module range");

   // Realisation needs a primary grant, and a phase is never both realised and skipped.
   a_flag_sets: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((realised_flags & ~primary_flags) == '0) &&
                    ((realised_flags & skipped_flags) == '0))
      else $error("inconsistent phase flags");

endmodule

bind traffic_signal_module_mill tsmm_checker u_tsmm_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .active_module  (rsp_chan.active_module),
   .module_start   (rsp_chan.module_start),
   .all_realised   (rsp_chan.all_realised),
   .primary_flags  (rsp_chan.primary_flags),
   .realised_flags (rsp_chan.realised_flags),
   .skipped_flags  (rsp_chan.skipped_flags)
);

// ===== tb/tb_top.sv =====
// Self-checking testbench for the traffic signal module mill: directed and random ticks.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import tsmm_pkg::*;

   logic clock = 1'b0;
   logic reset;

   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   tsmm_req_if req_chan ();
   tsmm_rsp_if rsp_chan ();

   traffic_signal_module_mill dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #10ns clock = ~clock;

   // Our own copy of the register file and of the mill state.
   logic [MODULE_W-1:0] cfg_count   = MODULE_COUNT_RST;
   logic [MODULE_W-1:0] cfg_waiting = PARK_MODULE_RST;
   tsmm_mask_type       cfg_phases [MODULE_SLOTS] = '{default: '0};
   logic [MODULE_W-1:0] mill_pos    = '0;
   tsmm_mask_type       prim_flags  = '0;
   tsmm_mask_type       real_flags  = '0;
   tsmm_mask_type       skip_flags  = '0;

   tsmm_result_type mill_outcomes [$];
   tsmm_mask_type   demand_mask = '0;

   bit idle_on     = 1'b1;
   int hold_cycles = 0;
   int ticks_sent  = 0;
   int results_seen = 0;
   int settings_run = 0;
   int advances    = 0;
   int waits_held  = 0;
   int errors      = 0;

   // One control tick of the mill: update the active module's flags, then move on.
   function automatic tsmm_result_type advance_mill(tsmm_mask_type rq, tsmm_mask_type nr,
                                                    tsmm_mask_type gr);
      tsmm_result_type     r;
      tsmm_mask_type       members;
      tsmm_mask_type       settled;
      logic [MODULE_W-1:0] span;
      logic                started;
      logic                drained;
      logic                hold;
      if (cfg_count == '0)
         span = MODULE_W'(1);
      else if (int'(cfg_count) > MAX_MODULES_DEF)
         span = MODULE_W'(MAX_MODULES_DEF);
      else
         span = cfg_count;
      members = (int'(mill_pos) < MODULE_SLOTS) ? cfg_phases[mill_pos] : '0;
      started = |(members & nr);
      settled = real_flags | skip_flags;
      prim_flags |= members & rq & ~settled;
      real_flags |= members & gr & prim_flags & ~settled;
      if (started) begin
         settled = real_flags | skip_flags;
         skip_flags |= members & ~settled & ~rq;
      end
      settled = real_flags | skip_flags;
      drained = ((members & rq & ~settled) == '0);
      r.module_start = 1'b0;
      if (drained) begin
         prim_flags &= ~members;
         real_flags &= ~members;
         skip_flags &= ~members;
         hold = (cfg_waiting < span) && (mill_pos == cfg_waiting) && (rq == '0);
         if (hold) begin
            waits_held++;
         end else begin
            if (int'(mill_pos) + 1 >= int'(span))
               mill_pos = '0;
            else
               mill_pos = mill_pos + 1'b1;
            r.module_start = 1'b1;
            advances++;
         end
      end
      r.active_module  = mill_pos;
      r.all_realised   = drained;
      r.primary_flags  = prim_flags;
      r.realised_flags = real_flags;
      r.skipped_flags  = skip_flags;
      return r;
   endfunction

   function automatic void check_field(string name, logic [PHASE_W-1:0] want,
                                       logic [PHASE_W-1:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%h, got 0x%h", name, want, got);
         errors++;
      end
   endfunction

   // Predict on every accepted tick and compare every accepted result beat.
   always @(posedge clock) begin : scoreboard
      tsmm_result_type due;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            mill_outcomes.push_back(advance_mill(req_chan.request_mask, req_chan.nonred_mask,
                                                 req_chan.green_mask));
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            results_seen++;
            if (mill_outcomes.size() == 0) begin
               $error("result beat arrived with no tick outstanding");
               errors++;
            end else begin
               due = mill_outcomes.pop_front();
               check_field("active_module", PHASE_W'(due.active_module),
                           PHASE_W'(rsp_chan.active_module));
               check_field("module_start", PHASE_W'(due.module_start),
                           PHASE_W'(rsp_chan.module_start));
               check_field("all_realised", PHASE_W'(due.all_realised),
                           PHASE_W'(rsp_chan.all_realised));
               check_field("primary_flags", due.primary_flags, rsp_chan.primary_flags);
               check_field("realised_flags", due.realised_flags, rsp_chan.realised_flags);
               check_field("skipped_flags", due.skipped_flags, rsp_chan.skipped_flags);
            end
         end
      end
   end

   // Result side: random stalls per beat, and a long hold-off when one is requested.
   initial begin : result_sink
      int stall;
      rsp_chan.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         stall = idle_on ? $urandom_range(0, 3) : 0;
         if (hold_cycles > 0) begin
            stall = hold_cycles;
            hold_cycles = 0;
         end
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
      end
   end

   task automatic send_tick(input tsmm_mask_type rq, input tsmm_mask_type nr,
                            input tsmm_mask_type gr);
      int gap;
      gap = idle_on ? $urandom_range(0, 3) : 0;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.request_mask <= rq;
      req_chan.nonred_mask  <= nr;
      req_chan.green_mask   <= gr;
      do @(posedge clock); while (!req_chan.ready);
      ticks_sent++;
   endtask

   // Waits until every tick has produced its result, then lets the pipeline settle.
   task automatic wait_idle();
      req_chan.valid <= 1'b0;
      while (results_seen < ticks_sent) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Leaves psel high: a following write starts its setup cycle at the same edge.
   task automatic write_reg(input tsmm_reg_type r, input logic [CSR_DATA_W-1:0] v);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'(4 * int'(r));
      csr_pwdata  <= v;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (r)
         REG_MODULE_COUNT: cfg_count = v[MODULE_W-1:0];
         REG_PARK_MODULE:  cfg_waiting = v[MODULE_W-1:0];
         default:          cfg_phases[int'(r) - int'(REG_MODULE0_PHASES)] = v[PHASE_W-1:0];
      endcase
   endtask

   task automatic apply_settings(input logic [MODULE_W-1:0] count,
                                 input logic [MODULE_W-1:0] waiting,
                                 input tsmm_mask_type masks [MODULE_SLOTS]);
      wait_idle();
      write_reg(REG_MODULE_COUNT, CSR_DATA_W'(count));
      write_reg(REG_PARK_MODULE, CSR_DATA_W'(waiting));
      for (int i = 0; i < MODULE_SLOTS; i++) begin
         write_reg(tsmm_reg_type'(int'(REG_MODULE0_PHASES) + i), CSR_DATA_W'(masks[i]));
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      settings_run++;
   endtask

   function automatic tsmm_mask_type thin(int density);
      tsmm_mask_type a;
      tsmm_mask_type b;
      tsmm_mask_type c;
      a = PHASE_W'($urandom);
      b = PHASE_W'($urandom);
      c = PHASE_W'($urandom);
      case (density)
         0:       return a & b & c;
         1:       return a & b;
         2:       return a;
         default: return a | b;
      endcase
   endfunction

   // Mostly plausible traffic: sticky demands that fade once served, green on primary
   // phases; the rest is unstructured noise.
   task automatic random_tick();
      tsmm_mask_type rq;
      if ($urandom_range(0, 3) == 0) begin
         send_tick(thin(2), thin(2), thin(2));
      end else begin
         if ($urandom_range(0, 7) == 0)
            demand_mask = thin($urandom_range(0, 3));
         demand_mask &= ~real_flags;
         rq = ($urandom_range(0, 11) == 0) ? '0 : demand_mask;
         send_tick(rq, thin($urandom_range(0, 3)), (prim_flags & thin(2)) | thin(0));
      end
   endtask

   task automatic random_masks(input int style, output tsmm_mask_type masks [MODULE_SLOTS]);
      int slot;
      masks = '{default: '0};
      case (style)
         0: begin
            for (int b = 0; b < PHASE_W; b++) begin
               slot = $urandom_range(0, MODULE_SLOTS);
               if (slot < MODULE_SLOTS)
                  masks[slot][b] = 1'b1;
            end
         end
         1: begin
            foreach (masks[i]) masks[i] = thin(1);
         end
         2: begin
            foreach (masks[i]) masks[i] = $urandom_range(0, 1) ? '1 : '0;
         end
         default: begin
            foreach (masks[i]) masks[i] = thin(0) | (PHASE_W'(1) << $urandom_range(0, 15));
         end
      endcase
   endtask

   // Reset values: four empty modules, waiting in module zero.
   task automatic test_reset_state();
      send_tick('0, '0, '0);
      send_tick('1, '1, '1);
      send_tick('0, '1, '0);
   endtask

   task automatic test_single_module_flow();
      apply_settings(3'd3, 3'd1,
                     '{16'h000F, 16'h00F0, 16'hFF00, 16'h0000, 16'h0000, 16'hFFFF});
      send_tick(16'h0003, 16'h0000, 16'h0000);
      send_tick(16'h0003, 16'h0000, 16'h0001);
      // Non-red shown: the idle phases of the module are skipped.
      send_tick(16'h0002, 16'h0001, 16'h0000);
      send_tick(16'h0002, 16'h0001, 16'h0002);
      send_tick(16'h0000, 16'h0000, 16'h0000);
      send_tick(16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_tick(16'h8000, 16'h0000, 16'h0000);
      // A primary phase whose demand has gone is skipped as well.
      send_tick(16'h0000, 16'h0100, 16'h0000);
   endtask

   task automatic test_count_limits();
      // A count of zero behaves as a single module; the waiting module is out of range.
      apply_settings(3'd0, 3'd7,
                     '{16'h00FF, 16'hFF00, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
      send_tick(16'h0001, 16'h0000, 16'h0000);
      send_tick(16'h0001, 16'h0001, 16'h0001);
      send_tick(16'h0000, 16'h0000, 16'h0000);
      // A count of seven saturates at six, so module five can be the waiting module.
      apply_settings(3'd7, 3'd5, '{default: 16'h0000});
      repeat (5) send_tick(16'h0000, 16'h0000, 16'h0000);
      send_tick(16'hFFFF, 16'h0000, 16'h0000);
   endtask

   task automatic test_count_lowered();
      apply_settings(3'd6, 3'd6,
                     '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0030});
      // Only module five holds the mill, so this parks it there from any position.
      repeat (6) send_tick(16'h0010, 16'h0000, 16'h0000);
      apply_settings(3'd2, 3'd6,
                     '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0030});
      send_tick(16'h0010, 16'h0000, 16'h0010);
      send_tick(16'h0000, 16'h0000, 16'h0000);
      send_tick(16'h0000, 16'h0000, 16'h0000);
   endtask

   task automatic test_random_settings();
      tsmm_mask_type       masks [MODULE_SLOTS];
      logic [MODULE_W-1:0] count;
      logic [MODULE_W-1:0] waiting;
      for (int k = 0; k < 8; k++) begin
         case (k)
            0:       count = 3'd1;
            1:       count = 3'd6;
            2:       count = 3'd0;
            3:       count = 3'd7;
            default: count = MODULE_W'($urandom_range(0, 7));
         endcase
         case (k)
            0:       waiting = 3'd0;
            1:       waiting = 3'd5;
            default: waiting = MODULE_W'($urandom_range(0, 7));
         endcase
         random_masks(k % 4, masks);
         apply_settings(count, waiting, masks);
         idle_on = (k % 3 != 2);
         repeat (60) random_tick();
      end
      idle_on = 1'b1;
   endtask

   // The result side holds off while ticks keep coming, so the input has to stall.
   task automatic test_backpressure();
      tsmm_mask_type masks [MODULE_SLOTS];
      random_masks(0, masks);
      apply_settings(3'd5, 3'd2, masks);
      idle_on = 1'b0;
      hold_cycles = 50;
      repeat (40) random_tick();
      idle_on = 1'b1;
   endtask

   initial begin
      reset                 <= 1'b1;
      req_chan.valid        <= 1'b0;
      req_chan.request_mask <= '0;
      req_chan.nonred_mask  <= '0;
      req_chan.green_mask   <= '0;
      csr_psel              <= 1'b0;
      csr_penable           <= 1'b0;
      csr_pwrite            <= 1'b0;
      csr_paddr             <= '0;
      csr_pwdata            <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_state();
      test_single_module_flow();
      test_count_limits();
      test_count_lowered();
      test_random_settings();
      test_backpressure();
      wait_idle();
      $display("Ran %0d ticks under %0d register settings, %0d results checked.",
               ticks_sent, settings_run, results_seen);
      $display("The mill advanced %0d times and held in its waiting module %0d times.",
               advances, waits_held);
      if (errors == 0)
         $display("[traffic_signal_module_mill] OK");
      else
         $display("[traffic_signal_module_mill] ERROR");
      $finish;
   end

   initial begin
      #2ms;
      $display("Timed out with %0d of %0d results seen.", results_seen, ticks_sent);
      $display("[traffic_signal_module_mill] ERROR");
      $finish;
   end

endmodule
